FILE: rtl/core/graph_relax_consumer_macros.svh
// assertion helpers shared by the graph relaxation consumer rtl
`ifndef GRAPH_RELAX_CONSUMER_MACROS_SVH
`define GRAPH_RELAX_CONSUMER_MACROS_SVH

`ifndef SYNTHESIS

// implication or plain property checked on every clock edge outside reset
`define GRC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define GRC_NEVER(lbl, clk, rst_n, cond, msg) \
	`GRC_ASSERT(lbl, clk, rst_n, !(cond), msg)

`else

`define GRC_ASSERT(lbl, clk, rst_n, prop, msg)

`define GRC_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/core/grc_pkg.sv
`default_nettype none

package grc_pkg;

	// partition and active list geometry
	localparam int VERTEX_DEPTH = 4096;
	localparam int IDX_W        = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int AL_SLOTS     = 64;
	localparam int SLOT_W       = (AL_SLOTS > 1) ? $clog2(AL_SLOTS) : 1;

	// fixed field widths
	localparam int ID_W     = 32;
	localparam int DIST_W   = 16;
	localparam int ESTART_W = 34;
	localparam int ECOUNT_W = 15;
	localparam int CFG_W    = 32;

	// request codes
	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_LOAD   = 1'b1;

	// configuration register indexes
	localparam logic CFG_VERTEX_OFFSET = 1'b0;
	localparam logic CFG_IDLE_LIMIT    = 1'b1;

	localparam logic [DIST_W-1:0] EMPTY_WEIGHT   = 16'hFFFF;
	localparam logic [DIST_W-1:0] IDLE_MAX       = 16'hFFFF;
	localparam logic [DIST_W-1:0] IDLE_LIMIT_RST = 16'd15000;

	typedef struct packed {
		logic                req_type;
		logic [ID_W-1:0]     vertex_id;
		logic [DIST_W-1:0]   weight;
		logic [ESTART_W-1:0] edge_start;
		logic [ECOUNT_W-1:0] edge_count;
	} item_t;

	typedef struct packed {
		logic                al_write;
		logic [SLOT_W-1:0]   al_slot;
		logic [DIST_W-1:0]   al_dist;
		logic [ESTART_W-1:0] al_edge_start;
		logic [ECOUNT_W-1:0] al_edge_count;
		logic                done_flag;
		logic                out_of_range;
	} result_t;

	// edge part of a vertex record
	typedef struct packed {
		logic [ESTART_W-1:0] edge_start;
		logic [ECOUNT_W-1:0] edge_count;
	} edge_rec_t;

	// update seen by the idle tracker
	typedef struct packed {
		logic upd;
		logic empty;
	} trk_req_t;

	// tracker values after the current update
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              done;
	} trk_t;

endpackage

`default_nettype wire

FILE: rtl/core/grc_vertex_store.sv
`default_nettype none

module grc_vertex_store (
	input  wire logic                          clk,
	input  wire logic                          rd_en,
	input  wire logic [grc_pkg::IDX_W-1:0]     rd_idx,
	output logic      [grc_pkg::DIST_W-1:0]    rd_dist,
	output grc_pkg::edge_rec_t                 rd_edge,
	input  wire logic                          wr_dist_en,
	input  wire logic                          wr_edge_en,
	input  wire logic [grc_pkg::IDX_W-1:0]     wr_idx,
	input  wire logic [grc_pkg::DIST_W-1:0]    wr_dist,
	input  wire grc_pkg::edge_rec_t            wr_edge
);

	// distance and edge records kept apart: updates rewrite distance only
	logic [grc_pkg::DIST_W-1:0] dist_mem [grc_pkg::VERTEX_DEPTH];
	grc_pkg::edge_rec_t         edge_mem [grc_pkg::VERTEX_DEPTH];

	logic [grc_pkg::DIST_W-1:0] rd_dist_q;
	grc_pkg::edge_rec_t         rd_edge_q;

	always_ff @(posedge clk) begin
		if (wr_dist_en) begin
			dist_mem[wr_idx] <= wr_dist;
		end
		if (rd_en) begin
			rd_dist_q <= dist_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_edge_en) begin
			edge_mem[wr_idx] <= wr_edge;
		end
		if (rd_en) begin
			rd_edge_q <= edge_mem[rd_idx];
		end
	end

	assign rd_dist = rd_dist_q;
	assign rd_edge = rd_edge_q;

endmodule

`default_nettype wire

FILE: rtl/core/grc_idle_track.sv
`default_nettype none

`include "graph_relax_consumer_macros.svh"

module grc_idle_track (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire grc_pkg::trk_req_t          req,
	input  wire logic [grc_pkg::DIST_W-1:0] idle_limit,
	output grc_pkg::trk_t                   nxt
);

	logic [grc_pkg::DIST_W-1:0] idle_q;
	logic [grc_pkg::SLOT_W-1:0] slot_q;
	logic                       done_q;

	logic [grc_pkg::DIST_W-1:0] idle_inc;
	logic [grc_pkg::DIST_W-1:0] idle_d;
	logic [grc_pkg::SLOT_W-1:0] slot_d;
	logic                       done_d;

	always_comb begin
		idle_inc = (idle_q == grc_pkg::IDLE_MAX) ? idle_q : idle_q + 1'b1;
		idle_d   = idle_q;
		slot_d   = slot_q;
		done_d   = done_q;
		if (req.upd) begin
			// pointer wraps at the slot count
			slot_d = (slot_q == grc_pkg::SLOT_W'(grc_pkg::AL_SLOTS - 1)) ?
				'0 : slot_q + 1'b1;
			if (req.empty) begin
				idle_d = idle_inc;
				done_d = done_q | (idle_inc > idle_limit);
			end else begin
				idle_d = '0;
				done_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= '0;
			slot_q <= '0;
			done_q <= 1'b0;
		end else begin
			idle_q <= idle_d;
			slot_q <= slot_d;
			done_q <= done_d;
		end
	end

	assign nxt.slot = slot_d;
	assign nxt.done = done_d;

	`GRC_ASSERT(a_done_rise_on_empty, clk, arst_n,
		$rose(done_q) |-> $past(req.upd && req.empty), "done rose without empty slot")
	`GRC_ASSERT(a_slot_moves_on_update, clk, arst_n,
		!$stable(slot_q) |-> $past(req.upd), "slot pointer moved without update")
	`GRC_ASSERT(a_done_needs_idle, clk, arst_n,
		done_q |-> (idle_q != '0), "done set with idle counter clear")

endmodule

`default_nettype wire

FILE: rtl/core/graph_relax_consumer.sv
`default_nettype none

`include "graph_relax_consumer_macros.svh"

// graph relaxation consumer: holds one partition of vertex records
// (distance, edge-list start, edge-list size) and relaxes incoming update
// messages against them. A transaction is taken when start is high and busy
// is low; each one yields exactly one result, shown on result for a single
// cycle with result_valid high once it has passed the stage 1 registers and
// the result register. The receiver cannot stall and must take every result
// in that cycle. Load transactions write a record; update transactions lower
// a stored distance and report an active-list entry, or count an empty queue
// slot (weight 65535) toward the done flag. The block cannot take a new
// transaction before the last one has left the stage 1 registers: busy is
// high for the cycle in which the vertex memory read returns and the record
// is modified and written back, so a following transaction always reads the
// updated record. Configuration writes are always ready and must be issued
// only while no transaction is in flight.
module graph_relax_consumer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// transaction input
	input  wire logic                        start,
	output logic                             busy,
	input  wire grc_pkg::item_t              item,
	// result output
	output logic                             result_valid,
	output grc_pkg::result_t                 result,
	// configuration write channel
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic                        cfg_index,
	input  wire logic [grc_pkg::CFG_W-1:0]   cfg_data
);

	// configuration registers
	logic [grc_pkg::ID_W-1:0]   vertex_offset_q;
	logic [grc_pkg::DIST_W-1:0] idle_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_offset_q <= '0;
			idle_limit_q    <= grc_pkg::IDLE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				grc_pkg::CFG_VERTEX_OFFSET: vertex_offset_q <= cfg_data;
				grc_pkg::CFG_IDLE_LIMIT:    idle_limit_q    <= cfg_data[grc_pkg::DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// accept stage: map the global id into the partition and start the read
	logic                       accept;
	logic [grc_pkg::ID_W-1:0]   local_id;
	logic                       in_range;
	logic                       is_empty;
	grc_pkg::trk_req_t          trk_req;
	grc_pkg::trk_t              trk_nxt;

	assign accept   = start && !busy;
	assign local_id = item.vertex_id - vertex_offset_q;   // wraps mod 2^32
	assign in_range = local_id < grc_pkg::ID_W'(grc_pkg::VERTEX_DEPTH);
	assign is_empty = (item.weight == grc_pkg::EMPTY_WEIGHT);

	// every update advances the slot pointer; empties feed the idle counter
	assign trk_req.upd   = accept && (item.req_type == grc_pkg::REQ_UPDATE);
	assign trk_req.empty = is_empty;

	grc_idle_track u_idle_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (trk_req),
		.idle_limit (idle_limit_q),
		.nxt        (trk_nxt)
	);

	// stage 1 registers: the transaction waits here for the record read
	logic                          valid_s1;
	logic                          req_type_s1;
	logic                          in_range_s1;
	logic                          empty_s1;
	logic [grc_pkg::IDX_W-1:0]     idx_s1;
	logic [grc_pkg::DIST_W-1:0]    weight_s1;
	grc_pkg::edge_rec_t            edge_s1;
	logic [grc_pkg::SLOT_W-1:0]    slot_s1;
	logic                          done_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1        <= item.req_type;
			in_range_s1        <= in_range;
			empty_s1           <= is_empty;
			idx_s1             <= local_id[grc_pkg::IDX_W-1:0];
			weight_s1          <= item.weight;
			edge_s1.edge_start <= item.edge_start;
			edge_s1.edge_count <= item.edge_count;
			slot_s1            <= trk_nxt.slot;
			done_s1            <= trk_nxt.done;
		end
	end

	// one transaction in flight at a time; the write-back lands before the next read
	assign busy = valid_s1;

	// vertex record memory
	logic [grc_pkg::DIST_W-1:0] rd_dist;
	grc_pkg::edge_rec_t         rd_edge;
	logic                       is_load_s1;
	logic                       improve_s1;
	logic                       wr_dist_en;
	logic                       wr_edge_en;

	assign is_load_s1 = (req_type_s1 == grc_pkg::REQ_LOAD);

	// relaxation: a non-empty in-range update that beats the stored distance
	assign improve_s1 = valid_s1 && !is_load_s1 && !empty_s1 && in_range_s1 &&
		(rd_dist > weight_s1);

	assign wr_edge_en = valid_s1 && is_load_s1 && in_range_s1;
	assign wr_dist_en = wr_edge_en || improve_s1;

	grc_vertex_store u_vertex_store (
		.clk        (clk),
		.rd_en      (accept),
		.rd_idx     (local_id[grc_pkg::IDX_W-1:0]),
		.rd_dist    (rd_dist),
		.rd_edge    (rd_edge),
		.wr_dist_en (wr_dist_en),
		.wr_edge_en (wr_edge_en),
		.wr_idx     (idx_s1),
		.wr_dist    (weight_s1),
		.wr_edge    (edge_s1)
	);

	// result formation; active-list fields of a non-improving transaction read as zero
	grc_pkg::result_t res_d;
	grc_pkg::result_t result_q;
	logic             result_valid_q;

	always_comb begin
		res_d = '0;
		res_d.done_flag = done_s1;
		if (is_load_s1) begin
			res_d.out_of_range = !in_range_s1;
		end else begin
			// an empty slot carries no meaningful id
			res_d.out_of_range = !empty_s1 && !in_range_s1;
		end
		if (improve_s1) begin
			res_d.al_write      = 1'b1;
			res_d.al_slot       = slot_s1;
			res_d.al_dist       = weight_s1;
			res_d.al_edge_start = rd_edge.edge_start;
			res_d.al_edge_count = rd_edge.edge_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`GRC_ASSERT(a_result_follows_accept, clk, arst_n,
		accept |=> ##1 result_valid, "accepted transaction produced no result")
	`GRC_NEVER(a_write_only_in_s1, clk, arst_n,
		(wr_dist_en || wr_edge_en) && !valid_s1, "record written with no transaction")
	`GRC_ASSERT(a_entry_clean, clk, arst_n,
		(result_valid && result.al_write) |-> (!result.out_of_range && !result.done_flag),
		"active entry reported with out-of-range or done")

endmodule

`default_nettype wire
